### hw/rtl/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg: shared types and constants of the CIGAR string parser
// Character codes, the classified character item that the front end passes
// to the back end, and the queue geometry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csp_pkg;

  // ASCII codes of interest
  localparam logic [7:0] CHAR_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE = 8'h39;  // '9'
  localparam logic [7:0] OP_M      = 8'h4D;  // 'M'
  localparam logic [7:0] OP_D      = 8'h44;  // 'D'
  localparam logic [7:0] OP_X      = 8'h58;  // 'X'
  localparam logic [7:0] OP_I      = 8'h49;  // 'I'
  localparam logic [7:0] OP_S      = 8'h53;  // 'S'

  localparam int CHAR_BITS  = 8;
  localparam int DIGIT_BITS = 4;
  localparam int COUNT_BITS = 16;

  // Queue between front and back end
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = 2;

  // What an op character adds to the totals
  typedef struct packed {
    logic ref_op;    // M, D, X
    logic read_op;   // M, I, X, S
    logic match_op;  // M
    logic clip_op;   // S
  } op_class_t;

  // One classified character
  typedef struct packed {
    logic                  is_digit;
    logic [DIGIT_BITS-1:0] digit;
    logic [CHAR_BITS-1:0]  code;
    op_class_t             cls;
    logic                  last;
  } item_t;

endpackage

`default_nettype wire

### hw/rtl/csp_if.sv
// ----------------------------------------------------------------------------
// csp_if: valid/ready channels of the CIGAR string parser
// Character channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface csp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       last_char;

  modport source (output valid, char_in, last_char, input ready);
  modport sink (input valid, char_in, last_char, output ready);
endinterface

interface csp_result_if #(
  parameter int LEN_BITS   = 28,
  parameter int TOTAL_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  elem_valid;
  logic [LEN_BITS-1:0]   elem_length;
  logic [7:0]            elem_op;
  logic                  is_final;
  logic [TOTAL_BITS-1:0] ref_length;
  logic [TOTAL_BITS-1:0] read_length;
  logic [LEN_BITS-1:0]   clip_start;
  logic [LEN_BITS-1:0]   clip_end;
  logic                  pure_match;
  logic [15:0]           elem_count;

  modport source (
    output valid, elem_valid, elem_length, elem_op, is_final, ref_length,
           read_length, clip_start, clip_end, pure_match, elem_count,
    input  ready
  );
  modport sink (
    input  valid, elem_valid, elem_length, elem_op, is_final, ref_length,
           read_length, clip_start, clip_end, pure_match, elem_count,
    output ready
  );
endinterface

`default_nettype wire

### hw/rtl/cigar_string_parser.sv
// ----------------------------------------------------------------------------
// cigar_string_parser: streaming CIGAR text parser
// Turns a CIGAR string, one character per transaction, into (length, op)
// elements and a closing summary of the whole string.
// ----------------------------------------------------------------------------
// Usage:
//   char_ch   carries one character (char_in) per transaction; last_char
//             marks the final character of a string.
//   result_ch carries at most one result per character: an element when a
//             digit follows an op, and always a closing result on the last
//             character (trailing element, reference and read lengths, soft
//             clips at both ends, element count, pure-match flag).
// Throughput: one character per cycle while result_ch.ready is high. The
//   parser state update (length * 10 + digit, saturating totals) sets it.
// Path: an accepted character is written into the four-entry queue, then
//   parsed into the result register when the back end pops it; the result
//   is valid from then until it is taken.
// Reset (rst, synchronous, active high): empties the queue, drops any
//   pending result and clears all parser state.
// Stall: while a valid result waits with result_ch.ready low, the result
//   register holds; the queue keeps taking characters until its four
//   entries are full, then char_ch.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cigar_string_parser #(
  parameter int LEN_BITS   = 28,
  parameter int TOTAL_BITS = 32
) (
  input  wire logic    clk,
  input  wire logic    rst,
  csp_char_if.sink     char_ch,
  csp_result_if.source result_ch
);

  // front end -> queue
  csp_pkg::item_t push_item;
  logic           push;
  logic           full;

  // queue -> back end
  csp_pkg::item_t head;
  logic           not_empty;
  logic           pop;

  // Classify characters and push them while the queue has room
  csp_front u_front (
    .char_ch   (char_ch),
    .full      (full),
    .push_item (push_item),
    .push      (push)
  );

  // Decouple intake from result delivery
  csp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (head)
  );

  // Advance the parser one character per cycle whenever the result
  // register is free or being drained
  csp_back #(
    .LEN_BITS   (LEN_BITS),
    .TOTAL_BITS (TOTAL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (not_empty),
    .q_item    (head),
    .pop       (pop),
    .result_ch (result_ch)
  );

endmodule

`default_nettype wire

### hw/rtl/csp_front.sv
// ----------------------------------------------------------------------------
// csp_front: character intake and classification
// Accepts characters while the queue has room and tags each as a digit or
// as an op with its contribution to the totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csp_front (
  csp_char_if.sink     char_ch,
  input  wire logic    full,
  output csp_pkg::item_t push_item,
  output logic         push
);

  logic [7:0] code;

  assign code          = char_ch.char_in;
  assign char_ch.ready = ~full;
  assign push          = char_ch.valid & ~full;

  always_comb begin
    push_item              = '0;
    push_item.code         = code;
    push_item.last         = char_ch.last_char;
    push_item.is_digit     = (code >= csp_pkg::CHAR_ZERO) && (code <= csp_pkg::CHAR_NINE);
    push_item.digit        = csp_pkg::DIGIT_BITS'(code - csp_pkg::CHAR_ZERO);
    push_item.cls.ref_op   = (code == csp_pkg::OP_M) || (code == csp_pkg::OP_D) ||
                             (code == csp_pkg::OP_X);
    push_item.cls.read_op  = (code == csp_pkg::OP_M) || (code == csp_pkg::OP_I) ||
                             (code == csp_pkg::OP_X) || (code == csp_pkg::OP_S);
    push_item.cls.match_op = (code == csp_pkg::OP_M);
    push_item.cls.clip_op  = (code == csp_pkg::OP_S);
  end

endmodule

`default_nettype wire

### hw/rtl/csp_queue.sv
// ----------------------------------------------------------------------------
// csp_queue: short register queue between front and back end
// First-in first-out store of classified characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire csp_pkg::item_t  push_item,
  input  wire logic            pop,
  output logic                 full,
  output logic                 not_empty,
  output csp_pkg::item_t       head
);

  localparam int PB = csp_pkg::QUEUE_PTR_BITS;

  csp_pkg::item_t slots [csp_pkg::QUEUE_DEPTH];
  logic [PB-1:0]  wr_ptr;
  logic [PB-1:0]  rd_ptr;
  logic [PB:0]    fill;

  assign full      = (fill == (PB+1)'(csp_pkg::QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/csp_back.sv
// ----------------------------------------------------------------------------
// csp_back: parser state, totals and result register
// Pops one classified character per cycle unless the result stalls, builds
// lengths, closes elements, keeps saturating totals and registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csp_back #(
  parameter int LEN_BITS   = 28,
  parameter int TOTAL_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire csp_pkg::item_t q_item,
  output logic                pop,
  csp_result_if.source        result_ch
);

  localparam int ACC_W = LEN_BITS + csp_pkg::DIGIT_BITS;
  localparam int SUM_W = ((LEN_BITS > TOTAL_BITS) ? LEN_BITS : TOTAL_BITS) + 1;
  localparam int CB    = csp_pkg::COUNT_BITS;

  // parser state
  logic [LEN_BITS-1:0]   length_acc;
  logic                  digits_seen;
  logic [7:0]            pending_op;
  csp_pkg::op_class_t    pending_cls;
  logic                  op_seen;
  logic [TOTAL_BITS-1:0] ref_total;
  logic [TOTAL_BITS-1:0] read_total;
  logic [CB-1:0]         count_total;
  logic [LEN_BITS-1:0]   first_clip;
  logic [LEN_BITS-1:0]   last_elem_len;
  logic                  last_is_clip;
  logic                  first_is_match;
  logic                  out_valid;

  // next values
  logic                  digit_emit;
  logic                  final_emit;
  logic                  emit;
  logic                  produce;
  logic [7:0]            e_op;
  csp_pkg::op_class_t    e_cls;
  logic [LEN_BITS-1:0]   acc_base;
  logic [ACC_W-1:0]      acc_ext;
  logic [ACC_W-1:0]      acc_wide;
  logic [LEN_BITS-1:0]   length_acc_next;
  logic [SUM_W-1:0]      ref_sum;
  logic [SUM_W-1:0]      read_sum;
  logic [TOTAL_BITS-1:0] ref_total_next;
  logic [TOTAL_BITS-1:0] read_total_next;
  logic [CB-1:0]         count_total_next;
  logic [LEN_BITS-1:0]   first_clip_next;
  logic                  first_is_match_next;
  logic [LEN_BITS-1:0]   last_elem_len_next;
  logic                  last_is_clip_next;

  assign pop = q_valid & (~out_valid | result_ch.ready);

  always_comb begin
    digit_emit = q_item.is_digit & op_seen;
    final_emit = q_item.last & ~q_item.is_digit & digits_seen;
    emit       = digit_emit | final_emit;
    produce    = emit | q_item.last;
    e_op       = op_seen ? pending_op : q_item.code;
    e_cls      = op_seen ? pending_cls : q_item.cls;

    // length * 10 + digit, clamp at all ones
    acc_base = digit_emit ? '0 : length_acc;
    acc_ext  = ACC_W'(acc_base);
    acc_wide = (acc_ext << 3) + (acc_ext << 1) + ACC_W'(q_item.digit);
    length_acc_next = (acc_wide[ACC_W-1:LEN_BITS] != '0) ? '1 : acc_wide[LEN_BITS-1:0];

    ref_sum  = SUM_W'(ref_total) + SUM_W'(length_acc);
    read_sum = SUM_W'(read_total) + SUM_W'(length_acc);

    ref_total_next      = ref_total;
    read_total_next     = read_total;
    count_total_next    = count_total;
    first_clip_next     = first_clip;
    first_is_match_next = first_is_match;
    last_elem_len_next  = last_elem_len;
    last_is_clip_next   = last_is_clip;
    if (emit) begin
      if (e_cls.ref_op) begin
        ref_total_next = (ref_sum[SUM_W-1:TOTAL_BITS] != '0) ? '1 :
                         ref_sum[TOTAL_BITS-1:0];
      end
      if (e_cls.read_op) begin
        read_total_next = (read_sum[SUM_W-1:TOTAL_BITS] != '0) ? '1 :
                          read_sum[TOTAL_BITS-1:0];
      end
      if (count_total == '0) begin
        first_clip_next     = e_cls.clip_op ? length_acc : '0;
        first_is_match_next = e_cls.match_op;
      end
      if (count_total != '1) begin
        count_total_next = count_total + 1'b1;
      end
      last_elem_len_next = length_acc;
      last_is_clip_next  = e_cls.clip_op;
    end
  end

  // control and parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      length_acc     <= '0;
      digits_seen    <= 1'b0;
      pending_op     <= '0;
      pending_cls    <= '0;
      op_seen        <= 1'b0;
      ref_total      <= '0;
      read_total     <= '0;
      count_total    <= '0;
      first_clip     <= '0;
      last_elem_len  <= '0;
      last_is_clip   <= 1'b0;
      first_is_match <= 1'b0;
    end else begin
      if (pop) begin
        out_valid <= produce;
      end else if (result_ch.ready) begin
        out_valid <= 1'b0;
      end

      if (pop) begin
        if (q_item.last) begin
          // close the string: back to the idle state
          length_acc     <= '0;
          digits_seen    <= 1'b0;
          pending_op     <= '0;
          pending_cls    <= '0;
          op_seen        <= 1'b0;
          ref_total      <= '0;
          read_total     <= '0;
          count_total    <= '0;
          first_clip     <= '0;
          last_elem_len  <= '0;
          last_is_clip   <= 1'b0;
          first_is_match <= 1'b0;
        end else begin
          if (q_item.is_digit) begin
            length_acc  <= length_acc_next;
            digits_seen <= 1'b1;
            if (op_seen) begin
              op_seen     <= 1'b0;
              pending_op  <= '0;
              pending_cls <= '0;
            end
          end else if (!op_seen) begin
            pending_op  <= q_item.code;
            pending_cls <= q_item.cls;
            op_seen     <= 1'b1;
          end
          ref_total      <= ref_total_next;
          read_total     <= read_total_next;
          count_total    <= count_total_next;
          first_clip     <= first_clip_next;
          last_elem_len  <= last_elem_len_next;
          last_is_clip   <= last_is_clip_next;
          first_is_match <= first_is_match_next;
        end
      end
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (pop && produce) begin
      result_ch.elem_valid  <= emit;
      result_ch.elem_length <= emit ? length_acc : '0;
      result_ch.elem_op     <= emit ? e_op : '0;
      result_ch.is_final    <= q_item.last;
      result_ch.ref_length  <= q_item.last ? ref_total_next : '0;
      result_ch.read_length <= q_item.last ? read_total_next : '0;
      result_ch.clip_start  <= q_item.last ? first_clip_next : '0;
      result_ch.clip_end    <= (q_item.last && last_is_clip_next && count_total_next != '0) ?
                               last_elem_len_next : '0;
      result_ch.pure_match  <= q_item.last && (count_total_next == CB'(1)) &&
                               first_is_match_next;
      result_ch.elem_count  <= q_item.last ? count_total_next : '0;
    end
  end

  assign result_ch.valid = out_valid;

endmodule

`default_nettype wire

### hw/rtl/csp_checker.sv
// ----------------------------------------------------------------------------
// csp_checker: port-level checks of the CIGAR string parser
// Watches the result channel for consistency of the fields over time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csp_checker #(
  parameter int LEN_BITS   = 28,
  parameter int TOTAL_BITS = 32
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  elem_valid,
  input wire logic [LEN_BITS-1:0]   elem_length,
  input wire logic [7:0]            elem_op,
  input wire logic                  is_final,
  input wire logic [TOTAL_BITS-1:0] ref_length,
  input wire logic [TOTAL_BITS-1:0] read_length,
  input wire logic                  pure_match,
  input wire logic [15:0]           elem_count
);

  // hold a stalled result unchanged
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(elem_length) &&
    $stable(elem_op) && $stable(is_final) && $stable(elem_count))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a result that is not final must carry an element and no totals
  a_mid_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_final |-> elem_valid && ref_length == '0 &&
    read_length == '0 && elem_count == '0 && !pure_match)
    else $error("non-final result malformed");

  // without an element the element fields are zero
  a_no_elem: assert property (@(posedge clk) disable iff (rst)
    out_valid && !elem_valid |-> elem_length == '0 && elem_op == '0)
    else $error("element fields set without element");

  // pure match means exactly one element
  a_pure_match: assert property (@(posedge clk) disable iff (rst)
    out_valid && pure_match |-> is_final && elem_count == 16'd1)
    else $error("pure match with wrong element count");

endmodule

bind cigar_string_parser csp_checker #(
  .LEN_BITS   (LEN_BITS),
  .TOTAL_BITS (TOTAL_BITS)
) u_csp_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (result_ch.valid),
  .out_ready   (result_ch.ready),
  .elem_valid  (result_ch.elem_valid),
  .elem_length (result_ch.elem_length),
  .elem_op     (result_ch.elem_op),
  .is_final    (result_ch.is_final),
  .ref_length  (result_ch.ref_length),
  .read_length (result_ch.read_length),
  .pure_match  (result_ch.pure_match),
  .elem_count  (result_ch.elem_count)
);

`default_nettype wire
